@@ hdl/bte_pkg.sv @@
`timescale 1ns / 1ps
package bte_pkg;

  localparam int TapeBitsDef = 15;
  localparam int MaxBurstDef = 64;
  localparam int CntW        = 7;   // holds a burst count up to 64

  localparam logic [3:0] OP_MOVE  = 4'd0;
  localparam logic [3:0] OP_ADD   = 4'd1;
  localparam logic [3:0] OP_PRINT = 4'd2;
  localparam logic [3:0] OP_GET   = 4'd3;
  localparam logic [3:0] OP_BZ    = 4'd4;
  localparam logic [3:0] OP_BNZ   = 4'd5;
  localparam logic [3:0] OP_CLEAR = 4'd6;
  localparam logic [3:0] OP_FIND  = 4'd7;
  localparam logic [3:0] OP_SCAN  = 4'd8;
  localparam logic [3:0] OP_COPY  = 4'd9;
  localparam logic [3:0] OP_MUL   = 4'd10;

  typedef enum logic [3:0] {
    K_MOVE, K_ADD, K_PRINT, K_GET, K_BZ, K_BNZ, K_CLEAR, K_FIND, K_SCAN, K_COPY,
    K_MUL, K_NOP
  } kind_e;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_SECOND, S_PRINT
  } state_e;

  typedef struct packed {
    kind_e            kind;
    logic [15:0]      amt;
    logic [15:0]      offs;
    logic [7:0]       in_byte;
    logic [7:0]       factor;
    logic [CntW-1:0]  cnt;
    logic             skip;   // no tape access needed, result is a bare last
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       taken;
    logic       unf;
    logic       last;
  } res_t;

endpackage

@@ hdl/brainfuck_tape_executor_top.sv @@
`timescale 1ns / 1ps
// Executes one optimized tape instruction per transfer (start high, busy low). A two-entry
// queue takes items while the executor works. After reset the executor zeroes all 2^TAPE_BITS
// tape cells (32768 by default); items queue meanwhile. Move, get, clear and nop need no tape
// read; add and branches read one cell, copy and multiply two, print reads one cell and then
// gives one byte per result, find reads each cell it steps to, scan_print two cells per byte;
// a print with a count of zero or less and a find with a zero step read nothing. Each step
// is bound by the single tape read port with its registered read. Every result shows for
// one cycle with result_valid_o and cannot be held off; the last one of an item has last_o set.
module brainfuck_tape_executor_top #(
  parameter int TAPE_BITS = bte_pkg::TapeBitsDef,
  parameter int MAX_BURST = bte_pkg::MaxBurstDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         operation_i,
  input  logic signed [15:0] amount_i,
  input  logic signed [15:0] offset_i,
  input  logic [7:0]         in_byte_i,
  output logic               result_valid_o,
  output logic [7:0]         out_byte_o,
  output logic               has_byte_o,
  output logic               branch_taken_o,
  output logic               unfinished_o,
  output logic               last_o
);
  import bte_pkg::*;

  item_t head;
  logic  head_valid, pop;
  res_t  res;

  bte_front #(.TAPE_BITS(TAPE_BITS), .MAX_BURST(MAX_BURST)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .amount_i     (amount_i),
    .offset_i     (offset_i),
    .in_byte_i    (in_byte_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  bte_back #(.TAPE_BITS(TAPE_BITS), .MAX_BURST(MAX_BURST)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .res_valid_o  (result_valid_o),
    .res_o        (res)
  );

  assign out_byte_o     = res.out_byte;
  assign has_byte_o     = res.has_byte;
  assign branch_taken_o = res.taken;
  assign unfinished_o   = res.unf;
  assign last_o         = res.last;
endmodule

@@ hdl/bte_ram.sv @@
`timescale 1ns / 1ps
module bte_ram #(
  parameter int ADDR_W = 15,
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);
  logic [DATA_W-1:0] mem [1 << ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ hdl/bte_front.sv @@
`timescale 1ns / 1ps
module bte_front #(
  parameter int TAPE_BITS = bte_pkg::TapeBitsDef,
  parameter int MAX_BURST = bte_pkg::MaxBurstDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [3:0]          operation_i,
  input  logic signed [15:0]  amount_i,
  input  logic signed [15:0]  offset_i,
  input  logic [7:0]          in_byte_i,
  output logic                head_valid_o,
  output bte_pkg::item_t      head_o,
  input  logic                pop_i
);
  import bte_pkg::*;

  localparam logic signed [16:0] MaxS = 17'(MAX_BURST);

  item_t       item;
  item_t       slot_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  count_q;
  logic        push;
  logic        amt_pos, amt_big;
  logic [TAPE_BITS-1:0] step_x;

  always_comb begin
    amt_pos = amount_i > 16'sd0;
    amt_big = $signed({amount_i[15], amount_i}) > MaxS;
    step_x  = TAPE_BITS'(amount_i);
    item.amt     = amount_i;
    item.offs    = offset_i;
    item.in_byte = in_byte_i;
    item.factor  = 8'd1;
    item.cnt     = amt_big ? CntW'(MAX_BURST) : CntW'(amount_i);
    item.skip    = 1'b0;
    case (operation_i)
      OP_MOVE:  item.kind = K_MOVE;
      OP_ADD:   item.kind = K_ADD;
      OP_PRINT: begin
        item.kind = K_PRINT;
        item.skip = !amt_pos;
      end
      OP_GET: begin
        item.kind = K_GET;
        item.skip = !amt_pos;
      end
      OP_BZ:    item.kind = K_BZ;
      OP_BNZ:   item.kind = K_BNZ;
      OP_CLEAR: item.kind = K_CLEAR;
      OP_FIND: begin
        item.kind = K_FIND;
        item.skip = step_x == '0;
      end
      OP_SCAN:  item.kind = K_SCAN;
      OP_COPY:  item.kind = K_COPY;
      OP_MUL: begin
        item.kind   = K_MUL;
        item.factor = offset_i[7:0];
      end
      default:  item.kind = K_NOP;
    endcase
  end

  assign busy         = count_q == 2'd2;
  assign push         = start && !busy;
  assign head_valid_o = count_q != 2'd0;
  assign head_o       = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      count_q <= count_q + 2'(push) - 2'(pop_i);
    end
  end
endmodule

@@ hdl/bte_back.sv @@
`timescale 1ns / 1ps
module bte_back #(
  parameter int TAPE_BITS = bte_pkg::TapeBitsDef,
  parameter int MAX_BURST = bte_pkg::MaxBurstDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  bte_pkg::item_t  head_i,
  output logic            pop_o,
  output logic            res_valid_o,
  output bte_pkg::res_t   res_o
);
  import bte_pkg::*;

  localparam int NW = $clog2(MAX_BURST + 1);

  state_e state_q, state_d;
  item_t  cur_q, cur_d;
  logic [TAPE_BITS-1:0] dp_q, dp_d, a_q, a_d, clr_q, clr_d;
  logic [TAPE_BITS:0]   steps_q, steps_d;
  logic [NW-1:0]        n_q, n_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [7:0]           pend_q, pend_d, prod_q, prod_d;
  logic                 rv_d, rv_q;
  res_t                 res_d, res_q;

  logic                 we;
  logic [TAPE_BITS-1:0] waddr, raddr;
  logic [7:0]           wdata, rdata;
  logic [TAPE_BITS-1:0] h_off, h_amt, c_off, c_amt, a_new;
  logic                 find_stop, scan_stop;

  bte_ram #(.ADDR_W(TAPE_BITS), .DATA_W(8)) u_tape (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign h_off     = TAPE_BITS'($signed(head_i.offs));
  assign h_amt     = TAPE_BITS'($signed(head_i.amt));
  assign c_off     = TAPE_BITS'($signed(cur_q.offs));
  assign c_amt     = TAPE_BITS'($signed(cur_q.amt));
  assign a_new     = dp_q + h_off;
  assign find_stop = rdata == 8'd0 || steps_q[TAPE_BITS];
  assign scan_stop = rdata == 8'd0 || n_q == NW'(MAX_BURST);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
      S_IDLE: begin
        if (head_valid_i) begin
          case (head_i.kind)
            K_MOVE, K_GET, K_CLEAR, K_NOP: state_d = S_IDLE;
            K_PRINT, K_FIND: state_d = head_i.skip ? S_IDLE : S_READ;
            default: state_d = S_READ;
          endcase
        end
      end
      S_READ: begin
        case (cur_q.kind)
          K_PRINT: state_d = S_PRINT;
          K_FIND:  state_d = find_stop ? S_IDLE : S_READ;
          K_SCAN:  state_d = scan_stop ? S_IDLE : S_SECOND;
          K_COPY, K_MUL: state_d = S_SECOND;
          default: state_d = S_IDLE;
        endcase
      end
      S_SECOND: state_d = (cur_q.kind == K_SCAN) ? S_READ : S_IDLE;
      S_PRINT:  if (cnt_q == CntW'(1)) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cur_d   = cur_q;
    dp_d    = dp_q;
    a_d     = a_q;
    clr_d   = clr_q;
    steps_d = steps_q;
    n_d     = n_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    prod_d  = prod_q;
    rv_d    = 1'b0;
    res_d   = '0;
    we      = 1'b0;
    waddr   = a_q;
    wdata   = 8'd0;
    raddr   = dp_q;
    pop_o   = 1'b0;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (head_valid_i) begin
          pop_o   = 1'b1;
          cur_d   = head_i;
          a_d     = a_new;
          steps_d = '0;
          n_d     = '0;
          cnt_d   = head_i.cnt;
          case (head_i.kind)
            K_ADD, K_PRINT: raddr = a_new;
            default:        raddr = dp_q;
          endcase
          case (head_i.kind)
            K_MOVE: begin
              dp_d = dp_q + h_amt;
              rv_d = 1'b1;
              res_d.last = 1'b1;
            end
            K_GET: begin
              we    = !head_i.skip;
              waddr = a_new;
              wdata = head_i.in_byte;
              rv_d  = 1'b1;
              res_d.last = 1'b1;
            end
            K_CLEAR: begin
              we    = 1'b1;
              waddr = a_new;
              rv_d  = 1'b1;
              res_d.last = 1'b1;
            end
            K_NOP: begin
              rv_d = 1'b1;
              res_d.last = 1'b1;
            end
            K_PRINT, K_FIND: begin
              rv_d = head_i.skip;
              res_d.last = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        case (cur_q.kind)
          K_ADD: begin
            we    = 1'b1;
            wdata = rdata + cur_q.amt[7:0];
            rv_d  = 1'b1;
            res_d.last = 1'b1;
          end
          K_PRINT: pend_d = rdata;
          K_BZ, K_BNZ: begin
            rv_d        = 1'b1;
            res_d.last  = 1'b1;
            res_d.taken = (rdata == 8'd0) == (cur_q.kind == K_BZ);
          end
          K_FIND: begin
            if (find_stop) begin
              rv_d = 1'b1;
              res_d.last = 1'b1;
            end else begin
              dp_d    = dp_q + c_amt;
              steps_d = steps_q + 1'b1;
              raddr   = dp_d;
            end
          end
          K_SCAN: begin
            // the byte held from the previous step goes out once we know if it ends the run
            if (scan_stop) begin
              rv_d           = 1'b1;
              res_d.last     = 1'b1;
              res_d.has_byte = n_q != '0;
              res_d.out_byte = (n_q != '0) ? pend_q : 8'd0;
              res_d.unf      = n_q == NW'(MAX_BURST) && rdata != 8'd0;
            end else begin
              rv_d           = n_q != '0;
              res_d.has_byte = 1'b1;
              res_d.out_byte = pend_q;
              dp_d  = dp_q + c_amt;
              raddr = dp_d;
            end
          end
          K_COPY, K_MUL: begin
            prod_d = 8'(cur_q.factor * rdata);
            a_d    = dp_q + c_amt;
            raddr  = a_d;
          end
          default: begin
            rv_d = 1'b1;
            res_d.last = 1'b1;
          end
        endcase
      end
      S_SECOND: begin
        if (cur_q.kind == K_SCAN) begin
          pend_d = rdata;
          n_d    = n_q + 1'b1;
          dp_d   = dp_q + c_off;
          raddr  = dp_d;
        end else begin
          we    = 1'b1;
          wdata = rdata + prod_q;
          rv_d  = 1'b1;
          res_d.last = 1'b1;
        end
      end
      S_PRINT: begin
        rv_d           = 1'b1;
        res_d.has_byte = 1'b1;
        res_d.out_byte = pend_q;
        res_d.last     = cnt_q == CntW'(1);
        cnt_d          = cnt_q - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    a_q     <= a_d;
    steps_q <= steps_d;
    n_q     <= n_d;
    cnt_q   <= cnt_d;
    pend_q  <= pend_d;
    prod_q  <= prod_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      dp_q    <= '0;
      clr_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      dp_q    <= dp_d;
      clr_q   <= clr_d;
      rv_q    <= rv_d;
    end
  end

  assign res_valid_o = rv_q;
  assign res_o       = res_q;
endmodule

@@ hdl/bte_checker.sv @@
`timescale 1ns / 1ps
module bte_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       result_valid_o,
  input logic [7:0] out_byte_o,
  input logic       has_byte_o,
  input logic       branch_taken_o,
  input logic       unfinished_o,
  input logic       last_o
);
  a_no_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !has_byte_o |-> out_byte_o == 8'd0)
    else $error("out_byte set without has_byte");

  a_unf_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && unfinished_o |-> last_o && has_byte_o)
    else $error("unfinished on a non-final or empty result");

  a_branch_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && branch_taken_o |-> last_o && !has_byte_o)
    else $error("branch_taken with a byte or not last");

  a_quiet_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !result_valid_o)
    else $error("result while the tape is still being cleared");
endmodule

bind brainfuck_tape_executor_top bte_checker u_bte_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .result_valid_o (result_valid_o),
  .out_byte_o     (out_byte_o),
  .has_byte_o     (has_byte_o),
  .branch_taken_o (branch_taken_o),
  .unfinished_o   (unfinished_o),
  .last_o         (last_o)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import bte_pkg::*;

  localparam int TapeSize  = 1 << TapeBitsDef;
  localparam int WdLimit   = 200000;  // covers the tape clear pass and an endless find
  localparam logic [3:0] OP_NOP     = 4'd11;
  localparam logic [3:0] OP_SPARE_LO = 4'd12;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;

  typedef struct {
    logic [3:0]  op;
    logic [15:0] amt;
    logic [15:0] offs;
    logic [7:0]  inb;
    bit          typed;     // expected single result given in the row
    logic [7:0]  t_byte;
    bit          t_has;
    bit          t_taken;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [3:0]         operation_i = '0;
  logic signed [15:0] amount_i = '0;
  logic signed [15:0] offset_i = '0;
  logic [7:0]         in_byte_i = '0;
  logic               result_valid_o;
  logic [7:0]         out_byte_o;
  logic               has_byte_o;
  logic               branch_taken_o;
  logic               unfinished_o;
  logic               last_o;

  brainfuck_tape_executor_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow state of the tape machine
  logic [7:0]  tape_mem [TapeSize];
  logic [14:0] dptr;
  res_t        out_q[$];
  int          errors = 0;
  int          xfers = 0;
  int          results = 0;
  int          bytes_seen = 0;
  int          taken_seen = 0;

  function automatic res_t mk_res(logic [7:0] b, bit h, bit t, bit u, bit l);
    res_t r;
    r.out_byte = b;
    r.has_byte = h;
    r.taken    = t;
    r.unf      = u;
    r.last     = l;
    return r;
  endfunction

  task automatic execute_item(logic [3:0] op, logic [15:0] amt, logic [15:0] offs,
                              logic [7:0] inb);
    logic [14:0] a;
    int          n;
    int          cnt;
    int          steps;
    res_t        r;
    n = 0;
    a = dptr + offs[14:0];
    case (op)
      OP_MOVE:  dptr = dptr + amt[14:0];
      OP_ADD:   tape_mem[a] = tape_mem[a] + amt[7:0];
      OP_PRINT: begin
        cnt = $signed(amt);
        if (cnt > MaxBurstDef) cnt = MaxBurstDef;
        for (int i = 0; i < cnt; i++) begin
          out_q.push_back(mk_res(tape_mem[a], 1, 0, 0, i == cnt - 1));
          n++;
        end
      end
      OP_GET:   if ($signed(amt) > 0) tape_mem[a] = inb;
      OP_BZ: begin
        out_q.push_back(mk_res(8'd0, 0, tape_mem[dptr] == 0, 0, 1));
        n = 1;
      end
      OP_BNZ: begin
        out_q.push_back(mk_res(8'd0, 0, tape_mem[dptr] != 0, 0, 1));
        n = 1;
      end
      OP_CLEAR: tape_mem[a] = 8'd0;
      OP_FIND: begin
        steps = 0;
        if (amt[14:0] != 0)
          while (tape_mem[dptr] != 0 && steps < TapeSize) begin
            dptr = dptr + amt[14:0];
            steps++;
          end
      end
      OP_SCAN: begin
        while (tape_mem[dptr] != 0 && n < MaxBurstDef) begin
          dptr = dptr + amt[14:0];
          out_q.push_back(mk_res(tape_mem[dptr], 1, 0, 0, 0));
          n++;
          dptr = dptr + offs[14:0];
        end
        if (n > 0) begin
          r = out_q.pop_back();
          r.last = 1;
          r.unf  = (n >= MaxBurstDef) && (tape_mem[dptr] != 0);
          out_q.push_back(r);
        end
      end
      OP_COPY: begin
        a = dptr + amt[14:0];
        tape_mem[a] = tape_mem[a] + tape_mem[dptr];
      end
      OP_MUL: begin
        a = dptr + amt[14:0];
        tape_mem[a] = tape_mem[a] + offs[7:0] * tape_mem[dptr];
      end
      default: ;
    endcase
    if (n == 0) out_q.push_back(mk_res(8'd0, 0, 0, 0, 1));
  endtask

  // holds start until the transfer, then updates the shadow state
  task automatic send(logic [3:0] op, logic [15:0] amt, logic [15:0] offs, logic [7:0] inb,
                      bit may_idle);
    @(negedge clk_i);
    while (may_idle && $urandom_range(99) < 24) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start       = 1'b1;
    operation_i = op;
    amount_i    = amt;
    offset_i    = offs;
    in_byte_i   = inb;
    do @(posedge clk_i); while (busy);
    xfers++;
    execute_item(op, amt, offs, inb);
  endtask

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (result_valid_o) begin
      results++;
      got = mk_res(out_byte_o, has_byte_o, branch_taken_o, unfinished_o, last_o);
      if (got.has_byte) bytes_seen++;
      if (got.taken) taken_seen++;
      if (out_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        want = out_q.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer or result
  int idle_cycles = 0;
  int last_x = 0;
  int last_r = 0;
  always @(posedge clk_i) begin
    if (xfers != last_x || results != last_r) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    last_x <= xfers;
    last_r <= results;
    if (idle_cycles > WdLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  row_t rows[] = '{
    '{OP_BZ,    16'h0000, 16'h0000, 8'h00, 1, 8'h00, 0, 1},  // fresh tape is zero
    '{OP_BNZ,   16'h0000, 16'h0000, 8'h00, 1, 8'h00, 0, 0},
    '{OP_PRINT, 16'h0000, 16'h0000, 8'h00, 1, 8'h00, 0, 0},  // zero count: bare last
    '{OP_PRINT, 16'h8000, 16'h7FFF, 8'h00, 1, 8'h00, 0, 0},  // negative count
    '{OP_ADD,   16'h0001, 16'h0000, 8'h00, 1, 8'h00, 0, 0},
    '{OP_PRINT, 16'h0001, 16'h0000, 8'h00, 1, 8'h01, 1, 0},
    '{OP_ADD,   16'h7FFF, 16'h7FFF, 8'h00, 0, 8'h00, 0, 0},
    '{OP_MOVE,  16'h7FFF, 16'h0000, 8'h00, 1, 8'h00, 0, 0},
    '{OP_PRINT, 16'h7FFF, 16'h0000, 8'h00, 0, 8'h00, 0, 0},  // saturates at the burst
    '{OP_GET,   16'h0001, 16'h8000, 8'hFF, 1, 8'h00, 0, 0},
    '{OP_GET,   16'h0000, 16'h0001, 8'hAA, 1, 8'h00, 0, 0},  // no store
    '{OP_GET,   16'h8000, 16'h0001, 8'h55, 1, 8'h00, 0, 0},
    '{OP_COPY,  16'h0001, 16'h0000, 8'h00, 0, 8'h00, 0, 0},
    '{OP_MUL,   16'hFFFF, 16'h8000, 8'h00, 0, 8'h00, 0, 0},
    '{OP_MUL,   16'h0002, 16'hFFFF, 8'h00, 0, 8'h00, 0, 0},
    '{OP_FIND,  16'h0000, 16'h0000, 8'h00, 1, 8'h00, 0, 0},  // step zero stops at once
    '{OP_FIND,  16'h8000, 16'h0000, 8'h00, 1, 8'h00, 0, 0},
    '{OP_ADD,   16'h0003, 16'h4000, 8'h00, 0, 8'h00, 0, 0},
    '{OP_FIND,  16'h4000, 16'h0000, 8'h00, 0, 8'h00, 0, 0},  // endless walk, full tape
    '{OP_SCAN,  16'h0000, 16'h0000, 8'h00, 0, 8'h00, 0, 0},  // burst limit, unfinished
    '{OP_SCAN,  16'h0001, 16'hFFFF, 8'h00, 0, 8'h00, 0, 0},
    '{OP_CLEAR, 16'h0000, 16'h0000, 8'h00, 1, 8'h00, 0, 0},
    '{OP_NOP,   16'hFFFF, 16'hFFFF, 8'hFF, 1, 8'h00, 0, 0},
    '{OP_SPARE_LO, 16'h1234, 16'h0000, 8'h00, 1, 8'h00, 0, 0},
    '{OP_SPARE_HI, 16'h0000, 16'h0000, 8'h00, 1, 8'h00, 0, 0}
  };

  function automatic logic [15:0] rnd_word(int near);
    int k;
    k = $urandom_range(9);
    if (k == 0) return 16'($urandom);
    if (k == 1) return ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
    return 16'($signed(near) - $urandom_range(2 * near));
  endfunction

  initial begin
    logic [3:0]  op;
    logic [15:0] amt;
    logic [15:0] offs;
    int          k;
    res_t        r;
    for (int i = 0; i < TapeSize; i++) tape_mem[i] = 8'd0;
    dptr = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) begin
      send(rows[i].op, rows[i].amt, rows[i].offs, rows[i].inb, 1);
      if (rows[i].typed) begin
        r = out_q.pop_back();
        out_q.push_back(mk_res(rows[i].t_byte, rows[i].t_has, rows[i].t_taken, 0, 1));
      end
    end

    for (int i = 0; i < 255; i++) begin
      k = $urandom_range(99);
      if      (k < 25) op = OP_ADD;
      else if (k < 40) op = OP_MOVE;
      else if (k < 50) op = OP_PRINT;
      else if (k < 56) op = OP_GET;
      else if (k < 62) op = OP_BZ;
      else if (k < 68) op = OP_BNZ;
      else if (k < 72) op = OP_CLEAR;
      else if (k < 77) op = OP_FIND;
      else if (k < 84) op = OP_SCAN;
      else if (k < 89) op = OP_COPY;
      else if (k < 94) op = OP_MUL;
      else             op = 4'($urandom_range(OP_NOP, OP_SPARE_HI));
      amt  = rnd_word(op == OP_ADD ? 120 : 6);
      offs = rnd_word(4);
      // keep find and scan walks short on a mostly empty tape
      if ((op == OP_FIND || op == OP_SCAN) && $urandom_range(3) != 0)
        amt = 16'($urandom_range(1, 3));
      send(op, amt, offs, 8'($urandom), !(i >= 100 && i < 180));
    end
    @(negedge clk_i);
    start = 1'b0;

    while (out_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Ran %0d instructions; %0d results, %0d printed bytes, %0d taken branches.",
             xfers, results, bytes_seen, taken_seen);
    if (errors == 0 && out_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
